// ===== design/efws_pkg.sv =====
// shared types and constants of the earliest-free worker scheduler
// no dependencies
package efws_pkg;

    localparam int WORKERS = 64;
    localparam int IDX_W   = 6;
    localparam int TIME_W  = 63;
    localparam int DUR_W   = 32;
    localparam int NUMW_W  = 7;
    localparam int CNT_W   = $clog2(WORKERS + 1);

    localparam logic [NUMW_W-1:0] NUMW_RESET = NUMW_W'(64);
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

    typedef struct packed {
        logic [DUR_W-1:0] job_duration;
        logic             new_batch;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  assigned_worker;
        logic [TIME_W-1:0] start_time;
    } t_rsp;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] ftime;
    } t_probe;

    // free-time update broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] ftime;
    } t_wr;

endpackage

// ===== design/efws_cell.sv =====
// one worker cell: holds the worker's next-free time, updates the running minimum
// depends on efws_pkg
module efws_cell import efws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_active,
    input  logic             i_clear,
    input  t_wr              i_wr,
    input  t_probe           i_probe,
    output t_probe           o_probe
);

    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] n_time;
    t_probe            r_probe;
    t_probe            n_probe;
    logic              take;

    always_comb begin
        n_time = r_time;
        if (i_clear) begin
            n_time = '0;
        end else if (i_wr.en && (i_wr.idx == i_idx)) begin
            n_time = i_wr.ftime;
        end
    end

    // strict less keeps the lower index on ties
    assign take = i_active && (!i_probe.found || (r_time < i_probe.ftime));

    always_comb begin
        n_probe = i_probe;
        if (take) begin
            n_probe.found = 1'b1;
            n_probe.idx   = i_idx;
            n_probe.ftime = r_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else begin
            r_time <= n_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
    end

    assign o_probe = r_probe;

endmodule

// ===== design/efws_chain.sv =====
// row of worker cells with the minimum probe travelling from cell 0 upwards
// depends on efws_pkg and efws_cell
module efws_chain import efws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NUMW_W-1:0] i_count,
    input  logic              i_clear,
    input  t_wr               i_wr,
    output t_probe            o_probe
);

    t_probe probe [WORKERS+1];

    assign probe[0] = '0;

    for (genvar g = 0; g < WORKERS; g++) begin : g_cell
        efws_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX_W'(g)),
            .i_active (NUMW_W'(g) < i_count),
            .i_clear  (i_clear),
            .i_wr     (i_wr),
            .i_probe  (probe[g]),
            .o_probe  (probe[g+1])
        );
    end

    assign o_probe = probe[WORKERS];

endmodule

// ===== design/earliest_free_worker_scheduler_unit.sv =====
// top level of the earliest-free worker scheduler: control, output register
// depends on efws_pkg, efws_chain and efws_cell
//
//  channel   direction  signals                              payload
//  request   in         i_req_valid / o_req_ready            i_req (t_req)
//  response  out        o_rsp_valid / i_rsp_ready            o_rsp (t_rsp)
//  config    in         i_cfg_we / i_cfg_wdata               num_workers
//
//  one request in flight at a time: a probe walks the 64-cell chain, one cell a
//  cycle, then the duration is added and the winner's free time written back
//  synchronous active-low reset: all free times zero, num_workers 64
//  a finished result sits in the output register; the next request is taken
//  while it waits, the write-back holds only if the register is still full
module earliest_free_worker_scheduler_unit import efws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_req              i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output t_rsp              o_rsp,
    input  logic              i_cfg_we,
    input  logic [NUMW_W-1:0] i_cfg_wdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [DUR_W-1:0]  r_dur;
    logic [NUMW_W-1:0] r_num;
    logic              r_out_valid;
    logic              n_out_valid;
    t_rsp              r_out;
    t_rsp              n_out;

    logic              accept;
    logic              finish;
    logic              clear;
    logic [NUMW_W-1:0] eff_count;
    t_probe            probe;
    t_wr               wr;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] next_time;

    assign accept = i_req_valid && o_req_ready;
    assign clear  = accept && i_req.new_batch;

    // zero means a single worker, above the cell count means all cells
    always_comb begin
        eff_count = r_num;
        if (r_num == '0) begin
            eff_count = NUMW_W'(1);
        end else if (r_num > NUMW_W'(WORKERS)) begin
            eff_count = NUMW_W'(WORKERS);
        end
    end

    // probe leaving the last cell is settled once the counter reaches WORKERS
    assign finish = (r_state == S_SCAN) && (r_cnt == CNT_W'(WORKERS))
                    && (!r_out_valid || i_rsp_ready);

    // saturating advance of the winner's free time
    assign sum       = {1'b0, probe.ftime} + (TIME_W+1)'(r_dur);
    assign next_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    always_comb begin
        wr.en    = finish;
        wr.idx   = probe.idx;
        wr.ftime = next_time;
    end

    efws_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (eff_count),
        .i_clear (clear),
        .i_wr    (wr),
        .o_probe (probe)
    );

    // control sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (r_cnt != CNT_W'(WORKERS)) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
        if (finish) begin
            n_out_valid           = 1'b1;
            n_out.assigned_worker = probe.idx;
            n_out.start_time      = probe.ftime;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_num       <= NUMW_RESET;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_num <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_dur <= i_req.job_duration;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // only one request in flight through the chain
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_req_ready)
        else $error("request taken while chain busy");

    // chosen worker is always one in use
    a_worker_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> ({1'b0, o_rsp.assigned_worker} < $past(eff_count)))
        else $error("worker out of use was chosen");

    // write-back only ever at the end of a full chain walk
    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> (r_cnt == CNT_W'(WORKERS)) && probe.found)
        else $error("write-back before probe settled");

endmodule

// ===== dv/earliest_free_worker_scheduler_unit_tb.sv =====
// testbench of the earliest-free worker scheduler: a directed table, then random phases
// over several worker counts and idling mixes, checked against a behavioural scheduler
// depends on efws_pkg and earliest_free_worker_scheduler_unit
module earliest_free_worker_scheduler_unit_tb import efws_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 5;
    localparam int HOLD_OFF_CYCLES = 400;         // long enough to fill the output register
    localparam int SETTLE_CYCLES   = WORKERS + 6; // one full probe walk plus write-back
    localparam int PHASE_ITEMS     = 128;
    localparam int N_PHASES        = 10;
    localparam int N_DIRECTED      = 20;
    localparam int MAX_REPORTED    = 10;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // one row of the directed part; known rows carry a hand-written result
    typedef struct packed {
        logic [DUR_W-1:0]  dur;
        logic              clear;
        logic              known;
        logic [IDX_W-1:0]  worker;
        logic [TIME_W-1:0] start;
    } t_directed_row;

    typedef struct {
        logic [NUMW_W-1:0] numw;
        t_idle_mode        mode;
        int unsigned       clear_pct;
    } t_phase;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_req_valid;
    logic              o_req_ready;
    t_req              i_req;
    logic              o_rsp_valid;
    logic              i_rsp_ready;
    t_rsp              o_rsp;
    logic              i_cfg_we;
    logic [NUMW_W-1:0] i_cfg_wdata;

    // behavioural copy of the scheduler state
    logic [TIME_W-1:0] free_at [WORKERS];
    logic [NUMW_W-1:0] worker_count = NUMW_RESET;

    // assignments still owed by the block, oldest first
    t_rsp        pending_assignments [$];
    int unsigned n_failures = 0;

    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    bit          hold_off_req  = 1'b0;

    // after reset, 64 workers all free at zero, so every known result reads straight off
    t_directed_row directed_rows [N_DIRECTED] = '{
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 6'd0, 63'd0},  // widest duration on worker 0
        '{32'h0000_0000, 1'b0, 1'b1, 6'd1, 63'd0},  // zero duration leaves worker 1 free
        '{32'h0000_0001, 1'b0, 1'b1, 6'd1, 63'd0},  // so worker 1 wins the tie again
        '{32'h8000_0000, 1'b0, 1'b1, 6'd2, 63'd0},
        '{32'h5555_5555, 1'b1, 1'b1, 6'd0, 63'd0},  // new batch back to worker 0
        '{32'hAAAA_AAAA, 1'b0, 1'b1, 6'd1, 63'd0},
        '{32'h0000_0007, 1'b1, 1'b1, 6'd0, 63'd0},
        '{32'h0000_0000, 1'b0, 1'b1, 6'd1, 63'd0},
        '{32'h0000_0001, 1'b0, 1'b1, 6'd1, 63'd0},
        '{32'h0000_0002, 1'b0, 1'b1, 6'd2, 63'd0},
        '{32'h0000_0003, 1'b0, 1'b0, 6'd0, 63'd0},
        '{32'h0000_0001, 1'b0, 1'b0, 6'd0, 63'd0},
        '{32'h0000_0000, 1'b0, 1'b0, 6'd0, 63'd0},
        '{32'hFFFF_FFFE, 1'b0, 1'b0, 6'd0, 63'd0},
        '{32'h0000_FFFF, 1'b0, 1'b0, 6'd0, 63'd0},
        '{32'h0000_0005, 1'b1, 1'b0, 6'd0, 63'd0},
        '{32'h0000_0005, 1'b0, 1'b0, 6'd0, 63'd0},
        '{32'h0000_0005, 1'b0, 1'b0, 6'd0, 63'd0},
        '{32'h0000_0004, 1'b0, 1'b0, 6'd0, 63'd0},
        '{32'hFFFF_0000, 1'b0, 1'b0, 6'd0, 63'd0}
    };

    // worker counts include the zero and over-range settings; some phases never clear,
    // so workers switched out earlier come back with their kept free times
    t_phase phases [N_PHASES] = '{
        '{7'd64,  IDLE_NONE,     5},
        '{7'd3,   IDLE_SENDER,   0},
        '{7'd64,  IDLE_RECEIVER, 3},
        '{7'd0,   IDLE_BOTH,     5},
        '{7'd1,   IDLE_NONE,     2},
        '{7'd127, IDLE_SENDER,   5},
        '{7'd65,  IDLE_RECEIVER, 0},
        '{7'd2,   IDLE_BOTH,     0},
        '{7'd33,  IDLE_NONE,     4},
        '{7'd63,  IDLE_RECEIVER, 5}
    };

    earliest_free_worker_scheduler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // generous fixed limit, roughly ten times the slowest expected run
    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        foreach (free_at[w]) free_at[w] = '0;
    end

    // earliest free worker among those in use, lowest index on a tie; its free time
    // moves on by the duration and saturates at the top of the time range
    function automatic t_rsp assign_job(t_req r);
        int unsigned       live;
        int unsigned       best;
        logic [TIME_W:0]   sum;
        t_rsp              res;
        live = (worker_count == 0) ? 1 : ((worker_count > WORKERS) ? WORKERS : worker_count);
        if (r.new_batch) begin
            foreach (free_at[w]) free_at[w] = '0;
        end
        best = 0;
        for (int unsigned w = 1; w < live; w++) begin
            if (free_at[w] < free_at[best]) best = w;
        end
        res.assigned_worker = best[IDX_W-1:0];
        res.start_time      = free_at[best];
        sum = {1'b0, free_at[best]} + (TIME_W+1)'(r.job_duration);
        free_at[best] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        return res;
    endfunction

    function automatic t_req make_request(int unsigned clear_pct);
        t_req r;
        // small durations keep free times close together, so ties are frequent
        case ($urandom_range(0, 9)) inside
            [0:3]:   r.job_duration = DUR_W'($urandom_range(0, 7));
            [4:6]:   r.job_duration = DUR_W'($urandom_range(0, 255));
            7:       r.job_duration = DUR_W'($urandom);
            8:       r.job_duration = '1;
            default: r.job_duration = '0;
        endcase
        r.new_batch = ($urandom_range(0, 99) < clear_pct);
        return r;
    endfunction

    task automatic log_failure(string msg);
        n_failures++;
        if (n_failures <= MAX_REPORTED) $display("%s", msg);
    endtask

    // entered and left at a falling edge; valid only drops for an idle gap
    task automatic offer_request(t_req r, bit known, t_rsp known_rsp);
        t_rsp predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        predicted = assign_job(r);
        pending_assignments.push_back(known ? known_rsp : predicted);
        @(negedge i_clk);
    endtask

    // stop offering until every owed result has come, then let the block settle
    task automatic drain_requests();
        i_req_valid <= 1'b0;
        while (pending_assignments.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_worker_count(logic [NUMW_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        worker_count = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // receiver: random stalls, or a long hold-off counted here when asked for
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_rsp_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_rsp_ready <= 1'b0;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES - 1;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_assignments.size() == 0) begin
                log_failure($sformatf("unexpected result: worker %0d start %0d",
                                      o_rsp.assigned_worker, o_rsp.start_time));
            end else begin
                want = pending_assignments.pop_front();
                if (o_rsp.assigned_worker !== want.assigned_worker
                        || o_rsp.start_time !== want.start_time) begin
                    log_failure($sformatf(
                        "mismatch: expected worker %0d start %0d, got worker %0d start %0d",
                        want.assigned_worker, want.start_time,
                        o_rsp.assigned_worker, o_rsp.start_time));
                end
            end
        end
    end

    // stimulus
    initial begin
        t_req req;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows run on the reset worker count
        foreach (directed_rows[k]) begin
            req.job_duration = directed_rows[k].dur;
            req.new_batch    = directed_rows[k].clear;
            offer_request(req, directed_rows[k].known,
                          {directed_rows[k].worker, directed_rows[k].start});
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_requests();
            write_worker_count(phases[p].numw);
            case (phases[p].mode)
                IDLE_NONE:     begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 77; rsp_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
                default:       begin send_idle_pct = 34; rsp_stall_pct = 34; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // receiver holds off while requests keep coming, so the input backs up
                if (p == 0 && n == 20) hold_off_req = 1'b1;
                // sender pauses mid-phase until everything owed has come back
                if (p == 3 && n == PHASE_ITEMS / 2) drain_requests();
                offer_request(make_request(phases[p].clear_pct), 1'b0, '0);
            end
        end

        drain_requests();
        if (pending_assignments.size() != 0)
            log_failure("requests left without a result");
        if (n_failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/efws_pkg.sv
design/efws_cell.sv
design/efws_chain.sv
design/earliest_free_worker_scheduler_unit.sv
dv/earliest_free_worker_scheduler_unit_tb.sv
